### sv/lsis_pkg.sv
// Shared widths, command codes and status codes for the sector index select block.
package lsis_pkg;

    // Default table geometry
    localparam int MAX_SECTORS_DEF = 64;
    localparam int ID_BITS_DEF     = 8;

    // Fixed field widths on the stream ports
    localparam int CMD_BITS      = 2;
    localparam int IN_ID_BITS    = 8;
    localparam int INDEX_BITS    = 8;
    localparam int STATUS_BITS   = 2;
    localparam int SLOT_OUT_BITS = 6;
    localparam int OUT_ID_BITS   = 8;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

endpackage

### sv/lsis_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lsis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/logical_sector_index_select.sv
// Top level: sector ID table with physical and stable sorted lookup.
//
// The block keeps the sector IDs of one track in physical order in one RAM and, in a
// second RAM, the same entries as {slot, id} pairs kept in ascending ID order (equal IDs
// in physical order). An append writes the next physical slot and inserts the pair into
// the sorted RAM by walking it from the top end down, moving each larger entry up one
// place, one entry per cycle, and drops the new pair in above the first entry that is
// not larger, or at the bottom when there is none. A lookup by slot or by logical
// rank is a single RAM read. Clear, append to a full table, lookups past the end and
// the unused command go straight to the result without a RAM access. A result is
// held back while the result side stalls and an earlier result still waits. One item
// is in work at a time; the result waits in an output register, so the next word is
// accepted while it is still pending. Every word yields exactly one result word. RAM
// contents are not cleared: only slots below the entry count are ever read.
module logical_sector_index_select #(
    parameter int MAX_SECTORS = lsis_pkg::MAX_SECTORS_DEF,
    parameter int ID_BITS     = lsis_pkg::ID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // sector_id[7:0], index[15:8]
    input  logic [2:0]  s_tuser,  // cmd[1:0], by_position[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // slot[5:0], found_id[13:6], zero[15:14]
    output logic [1:0]  m_tuser   // status[1:0]
);

    localparam int ADDR_BITS = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_SECTORS + 1);
    localparam int CMP_BITS  = (CNT_BITS > lsis_pkg::INDEX_BITS) ? CNT_BITS
                                                                 : lsis_pkg::INDEX_BITS;
    localparam int SORT_BITS = ID_BITS + ADDR_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // Input word fields
    logic [lsis_pkg::CMD_BITS-1:0]   in_cmd;
    logic [lsis_pkg::IN_ID_BITS-1:0] in_sector_id;
    logic [lsis_pkg::INDEX_BITS-1:0] in_index;
    logic                            in_by_position;
    logic [ID_BITS-1:0]              in_sid;

    assign in_sector_id   = s_tdata[7:0];
    assign in_index       = s_tdata[15:8];
    assign in_cmd         = s_tuser[1:0];
    assign in_by_position = s_tuser[2];
    assign in_sid         = ID_BITS'(in_sector_id);

    // Control and result registers
    logic [2:0]                       state_reg, state_next;
    logic [CNT_BITS-1:0]              count_reg, count_next;
    logic [ADDR_BITS-1:0]             p_reg, p_next;
    logic [ID_BITS-1:0]               sid_reg, sid_next;
    logic [ADDR_BITS-1:0]             new_slot_reg, new_slot_next;
    logic                             by_pos_reg, by_pos_next;
    logic [lsis_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0]             res_slot_reg, res_slot_next;
    logic [ID_BITS-1:0]               res_id_reg, res_id_next;
    logic                             m_valid_reg, m_valid_next;
    logic [lsis_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [lsis_pkg::SLOT_OUT_BITS-1:0] m_slot_reg, m_slot_next;
    logic [lsis_pkg::OUT_ID_BITS-1:0] m_id_reg, m_id_next;

    // RAM ports
    logic                 id_we;
    logic [ADDR_BITS-1:0] id_waddr, id_raddr;
    logic [ID_BITS-1:0]   id_wdata, id_rdata;
    logic                 st_we;
    logic [ADDR_BITS-1:0] st_waddr, st_raddr;
    logic [SORT_BITS-1:0] st_wdata, st_rdata;
    logic [ID_BITS-1:0]   st_rd_id;
    logic [ADDR_BITS-1:0] st_rd_slot;

    assign st_rd_id   = st_rdata[ID_BITS-1:0];
    assign st_rd_slot = st_rdata[ID_BITS +: ADDR_BITS];

    // Physical order table
    lsis_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(MAX_SECTORS)
    ) u_id_ram (
        .aclk (aclk),
        .we   (id_we),
        .waddr(id_waddr),
        .wdata(id_wdata),
        .raddr(id_raddr),
        .rdata(id_rdata)
    );

    // Sorted {slot, id} table
    lsis_ram #(
        .WIDTH(SORT_BITS),
        .DEPTH(MAX_SECTORS)
    ) u_sort_ram (
        .aclk (aclk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_id_reg, m_slot_reg};

    // Sequencer: accept, read, shift or insert, then hand the result to the output register
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        p_next          = p_reg;
        sid_next        = sid_reg;
        new_slot_next   = new_slot_reg;
        by_pos_next     = by_pos_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_id_next       = m_id_reg;

        id_we    = 1'b0;
        id_waddr = count_reg[ADDR_BITS-1:0];
        id_wdata = in_sid;
        id_raddr = p_reg;
        st_we    = 1'b0;
        st_waddr = p_reg;
        st_wdata = {new_slot_reg, sid_reg};
        st_raddr = p_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_status_next = lsis_pkg::STATUS_NOT_FOUND;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                    state_next      = ST_DONE;
                    unique case (in_cmd)
                        lsis_pkg::CMD_CLEAR: begin
                            count_next      = '0;
                            res_status_next = lsis_pkg::STATUS_OK;
                        end
                        lsis_pkg::CMD_APPEND: begin
                            if (count_reg == CNT_BITS'(MAX_SECTORS)) begin
                                res_status_next = lsis_pkg::STATUS_FULL;
                            end else begin
                                id_we           = 1'b1;
                                count_next      = count_reg + CNT_BITS'(1);
                                sid_next        = in_sid;
                                new_slot_next   = count_reg[ADDR_BITS-1:0];
                                res_status_next = lsis_pkg::STATUS_OK;
                                res_slot_next   = count_reg[ADDR_BITS-1:0];
                                res_id_next     = in_sid;
                                if (count_reg == '0) begin
                                    p_next     = '0;
                                    state_next = ST_INSERT;
                                end else begin
                                    p_next     = ADDR_BITS'(count_reg - CNT_BITS'(1));
                                    st_raddr   = ADDR_BITS'(count_reg - CNT_BITS'(1));
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        lsis_pkg::CMD_LOOKUP: begin
                            if (CMP_BITS'(in_index) < CMP_BITS'(count_reg)) begin
                                p_next      = ADDR_BITS'(in_index);
                                id_raddr    = ADDR_BITS'(in_index);
                                st_raddr    = ADDR_BITS'(in_index);
                                by_pos_next = in_by_position;
                                state_next  = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_status_next = lsis_pkg::STATUS_OK;
                if (by_pos_reg) begin
                    res_slot_next = p_reg;
                    res_id_next   = id_rdata;
                end else begin
                    res_slot_next = st_rd_slot;
                    res_id_next   = st_rd_id;
                end
                state_next = ST_DONE;
            end
            ST_SHIFT: begin
                // Move a larger entry up one place, or drop the new one in above it
                st_we    = 1'b1;
                st_waddr = p_reg + ADDR_BITS'(1);
                if (st_rd_id > sid_reg) begin
                    st_wdata = st_rdata;
                    if (p_reg == '0) begin
                        state_next = ST_INSERT;
                    end else begin
                        st_raddr = p_reg - ADDR_BITS'(1);
                        p_next   = p_reg - ADDR_BITS'(1);
                    end
                end else begin
                    st_wdata   = {new_slot_reg, sid_reg};
                    state_next = ST_DONE;
                end
            end
            ST_INSERT: begin
                st_we      = 1'b1;
                st_waddr   = p_reg;
                st_wdata   = {new_slot_reg, sid_reg};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = lsis_pkg::SLOT_OUT_BITS'(res_slot_reg);
                    m_id_next     = lsis_pkg::OUT_ID_BITS'(res_id_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset, payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        p_reg          <= p_next;
        sid_reg        <= sid_next;
        new_slot_reg   <= new_slot_next;
        by_pos_reg     <= by_pos_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_id_reg       <= m_id_next;
    end

endmodule

### dv/tb.sv
// Self-checking testbench for the sector ID table with physical and stable sorted lookup.
`timescale 1ns / 1ps

module tb;
    import lsis_pkg::*;

    // The stream allows the spare command code, so it is driven too
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int TABLE_DEPTH  = MAX_SECTORS_DEF;
    localparam int RANDOM_WORDS = 600;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [IN_ID_BITS-1:0] sid;
        logic [INDEX_BITS-1:0] idx;
        logic                  by_pos;
    } sector_cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic [OUT_ID_BITS-1:0]   id;
    } sector_result_t;

    typedef struct {
        sector_cmd_t    word;
        bit             typed;
        sector_result_t want;
    } directed_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // sector_id[7:0], index[15:8]
    logic [2:0]  s_tuser  = '0;  // cmd[1:0], by_position[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // slot[5:0], found_id[13:6], zero[15:14]
    logic [1:0]  m_tuser;        // status[1:0]

    // Mirror of the block's table
    logic [OUT_ID_BITS-1:0] id_by_slot [TABLE_DEPTH];
    logic [6:0]             entry_total = '0;

    sector_result_t pending_results[$];
    directed_row_t  directed_rows[$];
    int             mismatch_count = 0;
    int             words_sent     = 0;
    int             idle_cycles    = 0;
    bit             calm           = 1'b0;

    logical_sector_index_select i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one word to the mirrored table and return the result it should give
    function automatic sector_result_t table_step(input sector_cmd_t w);
        sector_result_t r;
        int             rank;
        r = '{status: STATUS_NOT_FOUND, slot: '0, id: '0};
        case (w.cmd)
            CMD_CLEAR: begin
                entry_total = '0;
                r.status    = STATUS_OK;
            end
            CMD_APPEND: begin
                if (entry_total >= TABLE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    id_by_slot[entry_total] = w.sid;
                    r = '{status: STATUS_OK, slot: entry_total[5:0], id: w.sid};
                    entry_total = entry_total + 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (w.idx < entry_total) begin
                    if (w.by_pos) begin
                        r = '{status: STATUS_OK, slot: w.idx[5:0], id: id_by_slot[w.idx]};
                    end else begin
                        // Stable rank: smaller IDs, then equal IDs in earlier slots
                        for (int i = 0; i < entry_total; i++) begin
                            rank = 0;
                            for (int j = 0; j < entry_total; j++) begin
                                if (id_by_slot[j] < id_by_slot[i] ||
                                    (id_by_slot[j] == id_by_slot[i] && j < i))
                                    rank++;
                            end
                            if (rank == w.idx)
                                r = '{status: STATUS_OK, slot: i[5:0], id: id_by_slot[i]};
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drive one word after a random gap, hold it until accepted, then predict
    task automatic send_word(input sector_cmd_t w, input bit typed, input sector_result_t want);
        int             gap;
        sector_result_t predicted;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.idx, w.sid};
        s_tuser  <= {w.by_pos, w.cmd};
        do @(posedge aclk); while (!s_tready);
        predicted = table_step(w);
        pending_results.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] sid,
                            input logic [7:0] idx, input logic by_pos);
        sector_cmd_t w;
        w = '{cmd: cmd, sid: sid, idx: idx, by_pos: by_pos};
        send_word(w, 1'b0, '0);
    endtask

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] sid,
                                    input logic [7:0] idx, input logic by_pos,
                                    input bit typed, input logic [1:0] status,
                                    input logic [5:0] slot, input logic [7:0] id);
        directed_row_t row;
        row.word  = '{cmd: cmd, sid: sid, idx: idx, by_pos: by_pos};
        row.typed = typed;
        row.want  = '{status: status, slot: slot, id: id};
        directed_rows.push_back(row);
    endfunction

    // Pick a lookup index, mostly inside the table
    function automatic logic [7:0] lookup_index();
        if (entry_total > 0 && $urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, entry_total - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Stall the result side for a random number of cycles per word
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Check each accepted result word against the oldest prediction
    always @(posedge aclk) begin
        sector_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, status", m_tuser, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[5:0] != want.slot)
                    report_mismatch("slot", m_tdata[5:0], want.slot);
                if (m_tdata[13:6] != want.id)
                    report_mismatch("found_id", m_tdata[13:6], want.id);
            end
        end
    end

    // End the run when neither side moves a word for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: directed table, then random fill and lookup phases
    initial begin
        int         n_append;
        int         n_lookup;
        int         id_base;
        bit         dup_ids;
        logic [7:0] sid;

        for (int i = 0; i < TABLE_DEPTH; i++)
            id_by_slot[i] = '0;

        // Empty table, extreme IDs, duplicates, edges of the lookup range
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   1'b0, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd255, 8'd255, 1'b1, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_APPEND, 8'd255, 8'd0,   1'b0, 1, STATUS_OK, 6'd0, 8'd255);
        add_row(CMD_APPEND, 8'd0,   8'd255, 1'b1, 1, STATUS_OK, 6'd1, 8'd0);
        add_row(CMD_APPEND, 8'd255, 8'd0,   1'b0, 1, STATUS_OK, 6'd2, 8'd255);
        add_row(CMD_APPEND, 8'd0,   8'd0,   1'b0, 1, STATUS_OK, 6'd3, 8'd0);
        add_row(CMD_APPEND, 8'd128, 8'd0,   1'b0, 1, STATUS_OK, 6'd4, 8'd128);
        for (int k = 0; k < 5; k++)
            add_row(CMD_LOOKUP, 8'd0, 8'(k), 1'b0, 0, STATUS_OK, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   1'b1, 0, STATUS_OK, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd4,   1'b1, 0, STATUS_OK, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd5,   1'b0, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd5,   1'b1, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd255, 1'b0, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_UNUSED, 8'd255, 8'd255, 1'b1, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_CLEAR,  8'd255, 8'd255, 1'b1, 1, STATUS_OK, 6'd0, 8'd0);
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   1'b1, 1, STATUS_NOT_FOUND, 6'd0, 8'd0);
        add_row(CMD_APPEND, 8'd7,   8'd0,   1'b0, 1, STATUS_OK, 6'd0, 8'd7);
        add_row(CMD_LOOKUP, 8'd0,   8'd0,   1'b0, 0, STATUS_OK, 6'd0, 8'd0);

        // Hold reset, then release it
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);

        // Fill the table with random content, then look it up; add some noise
        while (words_sent < RANDOM_WORDS + directed_rows.size()) begin
            calm    = ($urandom_range(0, 3) == 0);
            dup_ids = $urandom_range(0, 1);
            id_base = $urandom_range(0, 252);
            if ($urandom_range(0, 3) != 0)
                send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
            n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 12);
            for (int k = 0; k < n_append; k++) begin
                sid = dup_ids ? 8'(id_base + $urandom_range(0, 3)) : 8'($urandom);
                case ($urandom_range(0, 11))
                    0: send_cmd(CMD_LOOKUP, 8'($urandom), lookup_index(), 1'($urandom));
                    1: send_cmd(CMD_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
                    default: send_cmd(CMD_APPEND, sid, 8'($urandom), 1'($urandom));
                endcase
            end
            n_lookup = $urandom_range(1, 12);
            for (int k = 0; k < n_lookup; k++)
                send_cmd(CMD_LOOKUP, 8'($urandom), lookup_index(), 1'($urandom));
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray words
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
